>>> hdl/b2da_pkg.sv
// b2da_pkg: shared types and constants for the binary to decimal ascii converter
// depends on nothing; used by the interfaces, the cells, the formatter and the top level
`default_nettype none

package b2da_pkg;

    // widths fixed by the item format
    localparam int VALUE_W   = 32;
    localparam int NUM_DIGITS = 10;
    localparam int DIGIT_W   = 4;
    localparam int ASCII_W   = 6;
    localparam int COUNT_W   = 4;

    // one shift-and-adjust cell per input bit
    localparam int NUM_CELLS = VALUE_W;

    // ascii code of the character zero
    localparam logic [ASCII_W-1:0] ASCII_ZERO = 6'd48;

    // blanked digit code
    localparam logic [ASCII_W-1:0] ASCII_BLANK = 6'd0;

    // packed decimal digits, index 9 is the most significant
    typedef logic [NUM_DIGITS-1:0][DIGIT_W-1:0] t_bcd;

    // ascii digits, index 9 is the most significant
    typedef logic [NUM_DIGITS-1:0][ASCII_W-1:0] t_ascii;

    // data handed from one cell to the next
    typedef struct packed {
        t_bcd               bcd;
        logic [VALUE_W-1:0] bin;
    } t_stage;

endpackage

`default_nettype wire

>>> hdl/b2da_if.sv
// b2da_in_if / b2da_out_if: valid-ready channels for the converter
// depends on b2da_pkg for field widths
`default_nettype none

interface b2da_in_if;
    logic                         valid;
    logic                         ready;
    logic [b2da_pkg::VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface b2da_out_if;
    logic                         valid;
    logic                         ready;
    logic [b2da_pkg::ASCII_W-1:0] digit_9;
    logic [b2da_pkg::ASCII_W-1:0] digit_8;
    logic [b2da_pkg::ASCII_W-1:0] digit_7;
    logic [b2da_pkg::ASCII_W-1:0] digit_6;
    logic [b2da_pkg::ASCII_W-1:0] digit_5;
    logic [b2da_pkg::ASCII_W-1:0] digit_4;
    logic [b2da_pkg::ASCII_W-1:0] digit_3;
    logic [b2da_pkg::ASCII_W-1:0] digit_2;
    logic [b2da_pkg::ASCII_W-1:0] digit_1;
    logic [b2da_pkg::ASCII_W-1:0] digit_0;
    logic [b2da_pkg::COUNT_W-1:0] significant_count;

    modport source (
        output valid, input ready,
        output digit_9, output digit_8, output digit_7, output digit_6, output digit_5,
        output digit_4, output digit_3, output digit_2, output digit_1, output digit_0,
        output significant_count
    );
    modport sink (
        input valid, output ready,
        input digit_9, input digit_8, input digit_7, input digit_6, input digit_5,
        input digit_4, input digit_3, input digit_2, input digit_1, input digit_0,
        input significant_count
    );
endinterface

`default_nettype wire

>>> hdl/b2da_cell.sv
// b2da_cell: one shift-and-add-3 step of the binary to decimal conversion
// depends on b2da_pkg for t_stage and digit widths
`default_nettype none

module b2da_cell (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_valid,
    input  wire b2da_pkg::t_stage  i_data,
    output logic                   o_valid,
    output b2da_pkg::t_stage       o_data
);

    logic              r_valid;
    b2da_pkg::t_stage  r_data;
    b2da_pkg::t_stage  n_data;
    b2da_pkg::t_bcd    w_adj;

    // digits of five or more get three added so the shift carries correctly
    always_comb begin
        for (int d = 0; d < b2da_pkg::NUM_DIGITS; d++) begin
            if (i_data.bcd[d] >= 4'd5) begin
                w_adj[d] = i_data.bcd[d] + 4'd3;
            end else begin
                w_adj[d] = i_data.bcd[d];
            end
        end
    end

    // shift the top binary bit into the decimal digits
    always_comb begin
        n_data.bcd = {w_adj[b2da_pkg::NUM_DIGITS-1:0] << 1}
                   | b2da_pkg::t_bcd'(i_data.bin[b2da_pkg::VALUE_W-1]);
        n_data.bin = i_data.bin << 1;
    end

    // valid flag cleared by reset, data held on stall
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

>>> hdl/b2da_fmt.sv
// b2da_fmt: output register with leading-zero blanking and digit count
// depends on b2da_pkg for t_bcd, t_ascii and code constants
`default_nettype none

module b2da_fmt (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_en,
    input  wire logic                         i_valid,
    input  wire b2da_pkg::t_bcd               i_bcd,
    output logic                              o_valid,
    output b2da_pkg::t_ascii                  o_digits,
    output logic [b2da_pkg::COUNT_W-1:0]      o_count
);

    logic                          r_valid;
    b2da_pkg::t_ascii              r_digits;
    logic [b2da_pkg::COUNT_W-1:0]  r_count;
    b2da_pkg::t_ascii              n_digits;
    logic [b2da_pkg::COUNT_W-1:0]  n_count;
    logic                          w_seen;

    // walk from the top digit, blanking zeros until the first nonzero one
    always_comb begin
        w_seen  = 1'b0;
        n_count = '0;
        for (int d = b2da_pkg::NUM_DIGITS - 1; d >= 0; d--) begin
            w_seen = w_seen | (i_bcd[d] != '0);
            if (w_seen) begin
                n_digits[d] = b2da_pkg::ASCII_ZERO
                            + {{(b2da_pkg::ASCII_W - b2da_pkg::DIGIT_W){1'b0}}, i_bcd[d]};
                n_count     = n_count + 1'b1;
            end else begin
                n_digits[d] = b2da_pkg::ASCII_BLANK;
            end
        end
    end

    // result register, loads whenever the chain advances
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_digits <= n_digits;
            r_count  <= n_count;
        end
    end

    assign o_valid  = r_valid;
    assign o_digits = r_digits;
    assign o_count  = r_count;

endmodule

`default_nettype wire

>>> hdl/binary_to_decimal_ascii.sv
// binary_to_decimal_ascii: top level, a chain of shift-and-add-3 cells and an output formatter
// depends on b2da_pkg, b2da_if, b2da_cell and b2da_fmt
//
// usage
//   i_in carries one 32-bit unsigned value per item. o_out gives one result item per
//   input item: ten ascii digits, most significant first (digit_9), with leading zeros
//   blanked to code 0, and the count of significant digits. A value of zero gives all
//   digits blanked and a count of zero.
// pipeline and throughput
//   a value passes 32 cells, one per input bit, then the formatter register; the first
//   cell loads at the accepting edge. One item enters per cycle while the chain advances
//   and nothing stalls; each cell holds one item in flight.
// reset
//   i_rst_n low for one clock clears every valid flag; items in flight are dropped and
//   o_out.valid is low after the next edge.
// stall
//   when o_out.valid is high and o_out.ready is low, the whole chain holds and
//   i_in.ready drops; while the output register is empty, nothing at the output
//   blocks the chain.
`default_nettype none

module binary_to_decimal_ascii (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    b2da_in_if.sink    i_in,
    b2da_out_if.source o_out
);

    logic                                 w_advance;
    logic [b2da_pkg::NUM_CELLS:0]         w_valid;
    b2da_pkg::t_stage                     w_data [b2da_pkg::NUM_CELLS+1];
    b2da_pkg::t_ascii                     w_digits;

    // the chain moves whenever the output register is free or being emptied
    assign w_advance  = !o_out.valid || o_out.ready;
    assign i_in.ready = w_advance;

    // head of the chain: empty digits, value as the binary shift register
    assign w_valid[0]    = i_in.valid;
    assign w_data[0].bcd = '0;
    assign w_data[0].bin = i_in.value;

    // one cell per input bit
    for (genvar c = 0; c < b2da_pkg::NUM_CELLS; c++) begin : g_cell
        b2da_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_advance),
            .i_valid (w_valid[c]),
            .i_data  (w_data[c]),
            .o_valid (w_valid[c+1]),
            .o_data  (w_data[c+1])
        );
    end

    // blanking and output register
    b2da_fmt u_fmt (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_advance),
        .i_valid  (w_valid[b2da_pkg::NUM_CELLS]),
        .i_bcd    (w_data[b2da_pkg::NUM_CELLS].bcd),
        .o_valid  (o_out.valid),
        .o_digits (w_digits),
        .o_count  (o_out.significant_count)
    );

    assign o_out.digit_9 = w_digits[9];
    assign o_out.digit_8 = w_digits[8];
    assign o_out.digit_7 = w_digits[7];
    assign o_out.digit_6 = w_digits[6];
    assign o_out.digit_5 = w_digits[5];
    assign o_out.digit_4 = w_digits[4];
    assign o_out.digit_3 = w_digits[3];
    assign o_out.digit_2 = w_digits[2];
    assign o_out.digit_1 = w_digits[1];
    assign o_out.digit_0 = w_digits[0];

endmodule

`default_nettype wire

>>> hdl/b2da_chk.sv
// b2da_chk: port-level checks for binary_to_decimal_ascii, attached by bind
// depends on b2da_pkg for field widths
`default_nettype none

module b2da_chk (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         i_in_ready,
    input wire logic                         i_out_valid,
    input wire logic                         i_out_ready,
    input wire logic [b2da_pkg::ASCII_W-1:0] i_digit_9,
    input wire logic [b2da_pkg::ASCII_W-1:0] i_digit_0,
    input wire logic [b2da_pkg::COUNT_W-1:0] i_count
);

    // reset empties the output
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // a stalled result stays put
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_digit_9)
            && $stable(i_digit_0) && $stable(i_count))
        else $error("stalled result changed");

    // an empty output register never blocks the input
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input blocked with empty output");

    // a zero count goes with a blanked units digit and nothing else
    a_zero_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ((i_count == '0) == (i_digit_0 == b2da_pkg::ASCII_BLANK)))
        else $error("count and units digit disagree");

    // a shown top digit means all ten digits count
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_digit_9 != b2da_pkg::ASCII_BLANK)
            |-> (i_count == b2da_pkg::COUNT_W'(b2da_pkg::NUM_DIGITS)))
        else $error("top digit shown but count short");

endmodule

bind binary_to_decimal_ascii b2da_chk u_b2da_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_digit_9   (o_out.digit_9),
    .i_digit_0   (o_out.digit_0),
    .i_count     (o_out.significant_count)
);

`default_nettype wire

>>> tb/sv/tb_binary_to_decimal_ascii.sv
// tb_binary_to_decimal_ascii: self-checking bench for the binary to decimal ascii converter
// drives values over b2da_in_if, checks each result on b2da_out_if against a digit split
// depends on b2da_pkg, b2da_if and the binary_to_decimal_ascii rtl
`default_nettype none

module tb_binary_to_decimal_ascii;

    localparam int  PHASE_ITEMS = 270;
    localparam int  DRAIN_CYCLES = 40;
    localparam int  CYCLE_LIMIT = 200000;
    localparam logic [b2da_pkg::VALUE_W-1:0] VALUE_MAX = 32'hFFFF_FFFF;

    // one expected result item
    typedef struct packed {
        b2da_pkg::t_ascii             digits;
        logic [b2da_pkg::COUNT_W-1:0] count;
    } t_decimal_text;

    logic i_clk;
    logic i_rst_n;

    b2da_in_if  in_ch ();
    b2da_out_if out_ch ();

    binary_to_decimal_ascii u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    logic [b2da_pkg::VALUE_W-1:0]  pending_values[$];
    t_decimal_text                 expected_text[$];
    int                            sender_idle_pct;
    int                            receiver_stall_pct;
    int                            mismatches;
    int                            values_sent;
    int                            results_checked;
    int                            cycle_count;
    logic [b2da_pkg::NUM_DIGITS:0] counts_hit;

    // split a value into ascii digits, blanking zeros above the first nonzero digit
    function automatic t_decimal_text to_decimal_ascii(
        input logic [b2da_pkg::VALUE_W-1:0] value
    );
        t_decimal_text                res;
        logic [b2da_pkg::VALUE_W-1:0] rest;
        logic [b2da_pkg::DIGIT_W-1:0] dec[b2da_pkg::NUM_DIGITS];
        logic                         leading;
        int                           k;
        rest = value;
        for (k = 0; k < b2da_pkg::NUM_DIGITS; k++) begin
            dec[k] = b2da_pkg::DIGIT_W'(rest % 10);
            rest = rest / 10;
        end
        leading = 1'b1;
        res.count = '0;
        for (k = b2da_pkg::NUM_DIGITS - 1; k >= 0; k--) begin
            if (leading && dec[k] == '0) begin
                res.digits[k] = b2da_pkg::ASCII_BLANK;
            end else begin
                leading = 1'b0;
                res.digits[k] = b2da_pkg::ASCII_ZERO + b2da_pkg::ASCII_W'(dec[k]);
                res.count = res.count + 1'b1;
            end
        end
        return res;
    endfunction

    // random value: full range, a chosen digit count, or digits rich in zeros
    function automatic logic [b2da_pkg::VALUE_W-1:0] random_value();
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned acc;
        int              ndig;
        int              k;
        int              mode;
        mode = $urandom_range(3);
        ndig = $urandom_range(1, b2da_pkg::NUM_DIGITS);
        lo = 1;
        for (k = 1; k < ndig; k++) lo = lo * 10;
        hi = lo * 10 - 1;
        if (hi > VALUE_MAX) hi = VALUE_MAX;
        if (mode == 0) begin
            return $urandom;
        end else if (mode == 1) begin
            acc = lo + ({$urandom, $urandom} % (hi - lo + 1));
            return b2da_pkg::VALUE_W'(acc);
        end
        // sparse digits so that inner zeros show up often
        do begin
            acc = $urandom_range(1, 9);
            for (k = 1; k < ndig; k++) begin
                acc = acc * 10 + (($urandom_range(99) < 45) ? 0 : $urandom_range(1, 9));
            end
        end while (acc > VALUE_MAX);
        return b2da_pkg::VALUE_W'(acc);
    endfunction

    // clock
    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // sender: offer the next pending value, hold it until taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                expected_text.push_back(to_decimal_ascii(in_ch.value));
                values_sent <= values_sent + 1;
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (pending_values.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                    in_ch.valid <= 1'b1;
                    in_ch.value <= pending_values.pop_front();
                end else begin
                    in_ch.valid <= 1'b0;
                    in_ch.value <= $urandom;
                end
            end
        end
    end

    // receiver: random back-pressure and field-by-field comparison
    always @(posedge i_clk) begin
        t_decimal_text    want;
        b2da_pkg::t_ascii got;
        int               k;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
            if (out_ch.valid && out_ch.ready) begin
                got = {out_ch.digit_9, out_ch.digit_8, out_ch.digit_7, out_ch.digit_6,
                       out_ch.digit_5, out_ch.digit_4, out_ch.digit_3, out_ch.digit_2,
                       out_ch.digit_1, out_ch.digit_0};
                if (expected_text.size() == 0) begin
                    $error("result item with nothing expected: count %0d",
                           out_ch.significant_count);
                    mismatches++;
                end else begin
                    want = expected_text.pop_front();
                    for (k = b2da_pkg::NUM_DIGITS - 1; k >= 0; k--) begin
                        if (got[k] !== want.digits[k]) begin
                            $error("digit_%0d: expected %0d, actual %0d",
                                   k, want.digits[k], got[k]);
                            mismatches++;
                        end
                    end
                    if (out_ch.significant_count !== want.count) begin
                        $error("significant_count: expected %0d, actual %0d",
                               want.count, out_ch.significant_count);
                        mismatches++;
                    end
                    counts_hit[want.count] = 1'b1;
                    results_checked++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // stimulus and end of run
    initial begin
        int k;
        int phase;
        logic [b2da_pkg::VALUE_W-1:0] pow10;
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.value = '0;
        out_ch.ready = 1'b0;
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        mismatches = 0;
        values_sent = 0;
        results_checked = 0;
        cycle_count = 0;
        counts_hit = '0;

        // directed: zero, extremes, each power of ten, inner zeros
        pending_values.push_back(32'd0);
        pending_values.push_back(VALUE_MAX);
        pending_values.push_back(32'd9);
        pending_values.push_back(32'd999999999);
        pending_values.push_back(32'd4000000000);
        pending_values.push_back(32'd1000000001);
        pending_values.push_back(32'd2147483648);
        pending_values.push_back(32'd1020304050);
        pending_values.push_back(32'd3000000);
        pending_values.push_back(32'd1234567890);
        pending_values.push_back(32'd55555);
        pow10 = 32'd1;
        for (k = 0; k < b2da_pkg::NUM_DIGITS; k++) begin
            pending_values.push_back(pow10);
            pow10 = pow10 * 10;
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // phases: free flow, idle sender, stalling receiver, light idling on both
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 87; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 87; end
                default: begin sender_idle_pct = 10; receiver_stall_pct = 10; end
            endcase
            for (k = 0; k < PHASE_ITEMS; k++) pending_values.push_back(random_value());
            while (pending_values.size() != 0) @(posedge i_clk);
        end

        while (pending_values.size() != 0 || in_ch.valid || expected_text.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("converted %0d values, checked %0d results over four handshake phases",
                 values_sent, results_checked);
        $display("significant digit counts reached (bit per count 0..10): %b", counts_hit);
        if (mismatches == 0 && expected_text.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> binary_to_decimal_ascii.f
hdl/b2da_pkg.sv
hdl/b2da_if.sv
hdl/b2da_cell.sv
hdl/b2da_fmt.sv
hdl/binary_to_decimal_ascii.sv
hdl/b2da_chk.sv
tb/sv/tb_binary_to_decimal_ascii.sv
